/* design/lfl_pkg.sv */
// Package: shared constants, control types and state encoding for the lagged Fibonacci unit.
`timescale 1ns / 1ps

package lfl_pkg;

    localparam int LONG_LAG    = 100;
    localparam int SHORT_LAG   = 37;
    localparam int BLOCK_TOTAL = 1009;

    localparam int WORD_W = 32;
    localparam int IDX_W  = (LONG_LAG > 2) ? $clog2(LONG_LAG) : 1;

    // Tap of the short lag, counted from the cell that holds the long lag word
    localparam int SHORT_START = (LONG_LAG - (SHORT_LAG % LONG_LAG)) % LONG_LAG;

    localparam int DISCARD_COUNT = (BLOCK_TOTAL > LONG_LAG) ? (BLOCK_TOTAL - LONG_LAG) : 0;
    localparam int DISCARD_LAST  = (DISCARD_COUNT > 0) ? (DISCARD_COUNT - 1) : 0;
    localparam int DISC_W        = (DISCARD_COUNT > 2) ? $clog2(DISCARD_COUNT) : 1;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_DISCARD
    } state_t;

endpackage

/* design/lagged_fibonacci_luxury_prng_unit.sv */
// Top level: additive lagged Fibonacci generator (lags 100 and 37) with luxury decimation.
// Generate beat: sum registered on acceptance; one word per cycle in a block unless out_ready stalls.
// After every LONG_LAG words, DISCARD_COUNT (909) silent steps follow: 100 words kept per 1009 steps.
// Load beat: written at once if aligned, else the chain rotates until aligned and then writes.
// The rotation rate is set by the cell chain, which moves one word per cycle.
// Reset clears all cells, pointers and counters at once; no clearing pass follows.
`timescale 1ns / 1ps

module lagged_fibonacci_luxury_prng_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        cmd,
    input  logic [lfl_pkg::WORD_W-1:0]  seed_word,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lfl_pkg::WORD_W-1:0]  random_value
);

    // The ring lives in a chain of cells that rotates left by one word per step.
    // Cell 0 always holds the long lag word, cell SHORT_START the short lag word.
    // offset_reg is the physical ring slot currently sitting in cell 0.

    lfl_pkg::state_t state_reg;
    lfl_pkg::state_t state_next;

    logic [lfl_pkg::IDX_W-1:0]  offset_reg;
    logic [lfl_pkg::IDX_W-1:0]  offset_next;
    logic [lfl_pkg::IDX_W-1:0]  load_idx_reg;
    logic [lfl_pkg::IDX_W-1:0]  load_idx_next;
    logic [lfl_pkg::IDX_W-1:0]  block_pos_reg;
    logic [lfl_pkg::IDX_W-1:0]  block_pos_next;
    logic [lfl_pkg::DISC_W-1:0] disc_cnt_reg;
    logic [lfl_pkg::DISC_W-1:0] disc_cnt_next;
    logic [lfl_pkg::WORD_W-1:0] seed_reg;
    logic                       out_valid_reg;
    logic [lfl_pkg::WORD_W-1:0] out_data_reg;

    logic                       accept;
    logic                       gen;
    logic                       load_now;
    logic                       load_defer;
    logic                       block_end;
    logic                       step_en;
    logic                       shift_en;
    logic                       load_en;
    logic [lfl_pkg::WORD_W-1:0] load_data;
    logic [lfl_pkg::WORD_W-1:0] sum;
    logic [lfl_pkg::WORD_W-1:0] feedback;

    logic [lfl_pkg::WORD_W-1:0] cell_q [lfl_pkg::LONG_LAG];

    // ---------------------------------------------------------------
    // Handshake decode
    // ---------------------------------------------------------------
    // Take a beat only in idle, and only when the result register is free or emptying
    assign in_ready   = (state_reg == lfl_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept     = in_valid && in_ready;
    assign gen        = accept && cmd;
    assign load_now   = accept && !cmd && (offset_reg == '0);
    assign load_defer = accept && !cmd && (offset_reg != '0);
    assign block_end  = (block_pos_reg == lfl_pkg::IDX_W'(lfl_pkg::LONG_LAG - 1));

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lfl_pkg::ST_IDLE:
            begin
                if (load_defer)
                begin
                    state_next = lfl_pkg::ST_ALIGN;
                end
                else if (gen && block_end && (lfl_pkg::DISCARD_COUNT > 0))
                begin
                    state_next = lfl_pkg::ST_DISCARD;
                end
            end
            lfl_pkg::ST_ALIGN:
            begin
                if (offset_reg == '0)
                begin
                    state_next = lfl_pkg::ST_IDLE;
                end
            end
            lfl_pkg::ST_DISCARD:
            begin
                if (disc_cnt_reg == lfl_pkg::DISC_W'(lfl_pkg::DISCARD_LAST))
                begin
                    state_next = lfl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfl_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Chain control outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        step_en   = 1'b0;
        shift_en  = 1'b0;
        load_en   = 1'b0;
        load_data = seed_word;
        unique case (state_reg)
            lfl_pkg::ST_IDLE:
            begin
                step_en  = gen;
                shift_en = gen;
                load_en  = load_now;
            end
            lfl_pkg::ST_ALIGN:
            begin
                // rotate without summing until slot 0 sits in cell 0, then write the held seed
                shift_en  = (offset_reg != '0);
                load_en   = (offset_reg == '0);
                load_data = seed_reg;
            end
            lfl_pkg::ST_DISCARD:
            begin
                step_en  = 1'b1;
                shift_en = 1'b1;
            end
            default:
            begin
                step_en = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Feedback adder: long lag plus short lag, wrapping at 2^32
    // ---------------------------------------------------------------
    assign sum      = cell_q[0] + cell_q[lfl_pkg::SHORT_START];
    assign feedback = step_en ? sum : cell_q[0];

    // ---------------------------------------------------------------
    // Cell chain
    // ---------------------------------------------------------------
    for (genvar i = 0; i < lfl_pkg::LONG_LAG; i++)
    begin : g_cell
        lfl_pkg::cell_ctrl_t        ctrl;
        logic [lfl_pkg::WORD_W-1:0] din;

        assign ctrl.shift = shift_en;
        assign ctrl.load  = load_en && (load_idx_reg == lfl_pkg::IDX_W'(i));

        if (i < lfl_pkg::LONG_LAG - 1)
        begin : g_mid
            assign din = cell_q[i + 1];
        end
        else
        begin : g_tail
            assign din = feedback;
        end

        lfl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .din       (din),
            .load_data (load_data),
            .q         (cell_q[i])
        );
    end

    // ---------------------------------------------------------------
    // Pointers and counters
    // ---------------------------------------------------------------
    always_comb
    begin
        offset_next    = offset_reg;
        load_idx_next  = load_idx_reg;
        block_pos_next = block_pos_reg;
        disc_cnt_next  = disc_cnt_reg;

        // advance the chain offset on every rotation, wrap after the last slot
        if (shift_en)
        begin
            offset_next = (offset_reg == lfl_pkg::IDX_W'(lfl_pkg::LONG_LAG - 1))
                        ? '0 : offset_reg + 1'b1;
        end

        if (load_en)
        begin
            load_idx_next = (load_idx_reg == lfl_pkg::IDX_W'(lfl_pkg::LONG_LAG - 1))
                          ? '0 : load_idx_reg + 1'b1;
        end

        if (accept && !cmd)
        begin
            block_pos_next = '0;
        end
        else if (gen)
        begin
            block_pos_next = block_end ? '0 : block_pos_reg + 1'b1;
        end

        if (state_reg == lfl_pkg::ST_DISCARD)
        begin
            disc_cnt_next = (disc_cnt_reg == lfl_pkg::DISC_W'(lfl_pkg::DISCARD_LAST))
                          ? '0 : disc_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfl_pkg::ST_IDLE;
            offset_reg    <= '0;
            load_idx_reg  <= '0;
            block_pos_reg <= '0;
            disc_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            offset_reg    <= offset_next;
            load_idx_reg  <= load_idx_next;
            block_pos_reg <= block_pos_next;
            disc_cnt_reg  <= disc_cnt_next;
            // hold the result beat until taken; a new generate refills it in the same cycle
            if (gen)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (load_defer)
        begin
            seed_reg <= seed_word;
        end
        if (gen)
        begin
            out_data_reg <= sum;
        end
    end

    assign out_valid    = out_valid_reg;
    assign random_value = out_data_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_load_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        load_en |-> (offset_reg == '0))
        else $error("seed written while chain not aligned");

    a_gen_result: assert property (@(posedge clk) disable iff (!rst_n)
        gen |=> (out_valid && (random_value == $past(sum))))
        else $error("generate beat did not yield its sum");

    a_discard_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lfl_pkg::ST_DISCARD && $past(state_reg) == lfl_pkg::ST_IDLE)
        |-> ($past(block_pos_reg) == lfl_pkg::IDX_W'(lfl_pkg::LONG_LAG - 1)))
        else $error("discard run started mid block");

    a_block_range: assert property (@(posedge clk) disable iff (!rst_n)
        (block_pos_reg <= lfl_pkg::IDX_W'(lfl_pkg::LONG_LAG - 1))
        && (load_idx_reg <= lfl_pkg::IDX_W'(lfl_pkg::LONG_LAG - 1)))
        else $error("block or load index out of range");

endmodule

/* design/lfl_cell.sv */
// One word cell of the rotating lag chain.
`timescale 1ns / 1ps

module lfl_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lfl_pkg::cell_ctrl_t         ctrl,
    input  logic [lfl_pkg::WORD_W-1:0]  din,
    input  logic [lfl_pkg::WORD_W-1:0]  load_data,
    output logic [lfl_pkg::WORD_W-1:0]  q
);

    logic [lfl_pkg::WORD_W-1:0] word_reg;
    logic [lfl_pkg::WORD_W-1:0] word_next;

    // load and shift never coincide; load wins all the same
    always_comb
    begin
        priority if (ctrl.load)
        begin
            word_next = load_data;
        end
        else if (ctrl.shift)
        begin
            word_next = din;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign q = word_reg;

endmodule

/* tb/lagged_fibonacci_luxury_prng_unit_test.sv */
// Self-checking testbench for the lagged Fibonacci generator with luxury decimation.
`timescale 1ns / 1ps

module lagged_fibonacci_luxury_prng_unit_test;

    // Beat commands on the input channel
    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_GENERATE = 1'b1;

    // Our own view of the tap layout and of the decimation length
    localparam int unsigned SHORT_HOME =
        (lfl_pkg::LONG_LAG - (lfl_pkg::SHORT_LAG % lfl_pkg::LONG_LAG)) % lfl_pkg::LONG_LAG;
    localparam int unsigned SKIP_STEPS =
        (lfl_pkg::BLOCK_TOTAL > lfl_pkg::LONG_LAG)
        ? (lfl_pkg::BLOCK_TOTAL - lfl_pkg::LONG_LAG) : 0;

    localparam int unsigned SEED_BEATS   = 600;
    localparam int unsigned QUIET_LIMIT  = 20000;
    localparam int unsigned DRAIN_CYCLES = lfl_pkg::BLOCK_TOTAL + 2 * lfl_pkg::LONG_LAG;
    localparam int unsigned SQUEEZE_LEN  = 400;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef enum logic [1:0] {
        PH_STEADY,
        PH_SENDER_GAPS,
        PH_RECEIVER_STALLS,
        PH_BOTH_IDLE
    } traffic_phase_e;

    typedef struct packed {
        logic                       cmd;
        logic [lfl_pkg::WORD_W-1:0] word;
        traffic_phase_e             phase;
    } stim_beat_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       cmd = CMD_LOAD;
    logic [lfl_pkg::WORD_W-1:0] seed_word = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [lfl_pkg::WORD_W-1:0] random_value;

    traffic_phase_e    traffic_phase = PH_STEADY;

    stim_beat_t                 pending_beats[$];
    logic [lfl_pkg::WORD_W-1:0] expected_words[$];

    int unsigned beats_queued   = 0;
    int unsigned beats_accepted = 0;
    int unsigned words_checked  = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned squeeze_left   = 0;

    // Predictor state: the lag ring, both taps, words in the current block, next seed slot
    logic [lfl_pkg::WORD_W-1:0] fib_ring [lfl_pkg::LONG_LAG];
    int unsigned       long_tap       = 0;
    int unsigned       short_tap      = SHORT_HOME;
    int unsigned       words_in_block = 0;
    int unsigned       seed_slot      = 0;

    lagged_fibonacci_luxury_prng_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .seed_word    (seed_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .random_value (random_value)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hold reset from the start, then release it for good
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // One step of the recurrence: add the two taps, overwrite the oldest word, advance both taps
    function automatic logic [lfl_pkg::WORD_W-1:0] lfg_step();
        logic [lfl_pkg::WORD_W-1:0] sum;
        sum = fib_ring[long_tap] + fib_ring[short_tap];
        fib_ring[long_tap] = sum;
        long_tap  = (long_tap + 1) % lfl_pkg::LONG_LAG;
        short_tap = (short_tap + 1) % lfl_pkg::LONG_LAG;
        return sum;
    endfunction

    // Update the predicted state for one accepted beat; queue the word a generate beat yields
    function automatic void predict_beat(input logic beat_cmd,
                                         input logic [lfl_pkg::WORD_W-1:0] word);
        logic [lfl_pkg::WORD_W-1:0] result;
        if (beat_cmd == CMD_LOAD)
        begin
            // A load writes the next seed slot and realigns taps and block count
            fib_ring[seed_slot] = word;
            seed_slot      = (seed_slot + 1) % lfl_pkg::LONG_LAG;
            long_tap       = 0;
            short_tap      = SHORT_HOME;
            words_in_block = 0;
        end
        else
        begin
            result = lfg_step();
            words_in_block++;
            // Block complete: burn the luxury steps without returning them
            if (words_in_block >= lfl_pkg::LONG_LAG)
            begin
                for (int unsigned k = 0; k < SKIP_STEPS; k++)
                    void'(lfg_step());
                words_in_block = 0;
            end
            expected_words.push_back(result);
        end
    endfunction

    function automatic int unsigned sender_gap_pct(input traffic_phase_e ph);
        case (ph)
            PH_SENDER_GAPS: return 48;
            PH_BOTH_IDLE:   return 21;
            default:        return 0;
        endcase
    endfunction

    function automatic int unsigned receiver_stall_pct(input traffic_phase_e ph);
        case (ph)
            PH_RECEIVER_STALLS: return 48;
            PH_BOTH_IDLE:       return 21;
            default:            return 0;
        endcase
    endfunction

    // Seed words lean on the extremes now and then so the adder carry gets exercised
    function automatic logic [lfl_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, {(lfl_pkg::WORD_W-1){1'b0}}};
            3:       return {1'b0, {(lfl_pkg::WORD_W-1){1'b1}}};
            default: return $urandom;
        endcase
    endfunction

    // Append one beat; the traffic phase follows the position in the run.
    // Drop anything past the planned number of beats.
    task automatic queue_beat(input logic beat_cmd, input logic [lfl_pkg::WORD_W-1:0] word);
        stim_beat_t b;
        if (beats_queued >= SEED_BEATS)
            return;
        b.cmd  = beat_cmd;
        b.word = word;
        if (beats_queued < 150)
            b.phase = PH_STEADY;
        else if (beats_queued < 300)
            b.phase = PH_SENDER_GAPS;
        else if (beats_queued < 450)
            b.phase = PH_RECEIVER_STALLS;
        else
            b.phase = PH_BOTH_IDLE;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic note_mismatch(input string what, input logic [lfl_pkg::WORD_W-1:0] want,
                                 input logic [lfl_pkg::WORD_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch %0d (%s): expected %h, got %h", mismatch_count, what, want, got);
    endtask

    // Driver: predict on every accepted beat, then offer the next one unless the sender idles
    always @(posedge clk or negedge rst_n)
    begin : drive_inputs
        stim_beat_t next_beat;
        logic       present;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd      <= CMD_LOAD;
            seed_word <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_beat(cmd, seed_word);
                beats_accepted++;
            end
            // Hold the current beat until the block takes it
            if (!in_valid || in_ready)
            begin
                present = 1'b0;
                if (pending_beats.size() != 0)
                    present = ($urandom_range(0, 99) >= sender_gap_pct(pending_beats[0].phase));
                if (present)
                begin
                    next_beat = pending_beats.pop_front();
                    in_valid      <= 1'b1;
                    cmd           <= next_beat.cmd;
                    seed_word     <= next_beat.word;
                    traffic_phase <= next_beat.phase;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted word against the oldest prediction and drive out_ready.
    // Twice in the run, hold out_ready low for a long stretch so the block backs up into
    // its input while the driver keeps offering beats.
    always @(posedge clk or negedge rst_n)
    begin : check_outputs
        logic [lfl_pkg::WORD_W-1:0] want;
        int unsigned                hold_next;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            hold_next = (squeeze_left != 0) ? squeeze_left - 1 : 0;
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    note_mismatch("word with no prediction", '0, random_value);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (random_value !== want)
                        note_mismatch("random_value", want, random_value);
                end
                if (words_checked == 29 || words_checked == 299)
                    hold_next = SQUEEZE_LEN;
                words_checked++;
            end
            squeeze_left = hold_next;
            out_ready <= (hold_next == 0) &&
                         ($urandom_range(0, 99) >= receiver_stall_pct(traffic_phase));
        end
    end

    // Watchdog: give up once nothing has moved on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
                $display("FAIL lagged_fibonacci_luxury_prng_unit");
                $finish;
            end
        end
    end

    initial
    begin : run_control
        int unsigned loads;
        int unsigned gens;
        for (int unsigned k = 0; k < lfl_pkg::LONG_LAG; k++)
            fib_ring[k] = '0;

        // Generate before any seed: ring is all zero
        repeat (3) queue_beat(CMD_GENERATE, '0);
        // Seed the first slots with the extremes of the word
        queue_beat(CMD_LOAD, '1);
        queue_beat(CMD_LOAD, '0);
        queue_beat(CMD_LOAD, 32'h8000_0000);
        queue_beat(CMD_LOAD, 32'h7FFF_FFFF);
        queue_beat(CMD_LOAD, 32'h0000_0001);
        queue_beat(CMD_LOAD, 32'h5555_5555);
        queue_beat(CMD_LOAD, 32'hAAAA_AAAA);
        repeat (6) queue_beat(CMD_GENERATE, $urandom);
        // Load after generating: taps were moved, so the block has to realign
        repeat (2) queue_beat(CMD_LOAD, '1);
        repeat (4) queue_beat(CMD_GENERATE, '0);

        // Mostly seed-then-generate sequences; long generate runs cross the decimation gap,
        // long seed runs wrap the load slot. The rest is a random mix of both commands.
        while (beats_queued < SEED_BEATS)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    loads = $urandom_range(lfl_pkg::LONG_LAG, lfl_pkg::LONG_LAG + 30);
                else
                    loads = $urandom_range(1, 6);
                if ($urandom_range(0, 3) == 0)
                    gens = $urandom_range(lfl_pkg::LONG_LAG, 2 * lfl_pkg::LONG_LAG + 40);
                else
                    gens = $urandom_range(1, 40);
                repeat (loads) queue_beat(CMD_LOAD, pick_word());
                repeat (gens) queue_beat(CMD_GENERATE, pick_word());
            end
            else
            begin
                repeat ($urandom_range(1, 20))
                    queue_beat(logic'($urandom_range(0, 1)), pick_word());
            end
        end

        // Drain: every beat taken, every word seen, then allow a full luxury gap
        while (beats_accepted != beats_queued)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("PASS lagged_fibonacci_luxury_prng_unit");
        else
            $display("FAIL lagged_fibonacci_luxury_prng_unit");
        $finish;
    end

endmodule
